// ===== rtl/erff_pkg.sv =====
// ----------------------------------------------------------------------------
// erff_pkg
// Shared types and constants of the receive frame filter: header layout,
// verdict codes, the per-frame record handed from front to back, and config.
// ----------------------------------------------------------------------------
package erff_pkg;

    localparam int MAC_W      = 48;
    localparam int TYPE_W     = 16;
    localparam int COUNT_W    = 15;
    localparam int PAYLOAD_W  = 14;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    // byte positions in the header
    localparam logic [COUNT_W-1:0] DEST_END   = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] SRC_END    = COUNT_W'(12);
    localparam logic [COUNT_W-1:0] HDR_BYTES  = COUNT_W'(14);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    localparam logic [TYPE_W-1:0] TYPE_ARP  = 16'h0806;
    localparam logic [TYPE_W-1:0] TYPE_IPV4 = 16'h0800;
    localparam logic [MAC_W-1:0]  MAC_BCAST = {MAC_W{1'b1}};
    localparam int                MCAST_BIT = 40;

    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST = PAYLOAD_W'(1500);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATION_MAC = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_ARP     = 3'd0,
        VERDICT_IPV4    = 3'd1,
        VERDICT_INVALID = 3'd2,
        VERDICT_NOTUS   = 3'd3,
        VERDICT_UNSUP   = 3'd4
    } verdict_t;

    // header fields and length of one finished frame
    typedef struct packed {
        logic [MAC_W-1:0]   dest_mac;
        logic [MAC_W-1:0]   src_mac;
        logic [TYPE_W-1:0]  ether_type;
        logic [COUNT_W-1:0] frame_len;
    } frame_rec_t;

    typedef struct packed {
        logic [MAC_W-1:0]     station_mac;
        logic [PAYLOAD_W-1:0] max_payload;
    } filt_cfg_t;

endpackage

// ===== rtl/erff_front.sv =====
// ----------------------------------------------------------------------------
// erff_front
// Byte intake: shifts in the header fields, counts frame bytes with
// saturation and pushes one frame record into the queue on the last byte.
// ----------------------------------------------------------------------------
module erff_front import erff_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_last_byte,
    input  logic              q_full,
    output logic              q_push,
    output frame_rec_t        q_push_rec
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [MAC_W-1:0]   dest_reg, dest_next;
    logic [MAC_W-1:0]   src_reg, src_next;
    logic [TYPE_W-1:0]  type_reg, type_next;
    logic               accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    // header capture and byte count for the byte being accepted
    always_comb begin
        dest_next  = dest_reg;
        src_next   = src_reg;
        type_next  = type_reg;
        count_next = count_reg;
        if (count_reg < DEST_END) begin
            dest_next = {dest_reg[MAC_W-BYTE_W-1:0], s_data_byte};
        end else if (count_reg < SRC_END) begin
            src_next = {src_reg[MAC_W-BYTE_W-1:0], s_data_byte};
        end else if (count_reg < HDR_BYTES) begin
            type_next = {type_reg[TYPE_W-BYTE_W-1:0], s_data_byte};
        end
        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    // finished frame record
    assign q_push                = accept && s_last_byte;
    assign q_push_rec.dest_mac   = dest_next;
    assign q_push_rec.src_mac    = src_next;
    assign q_push_rec.ether_type = type_next;
    assign q_push_rec.frame_len  = count_next;

    // frame state, cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            dest_reg  <= '0;
            src_reg   <= '0;
            type_reg  <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                count_reg <= '0;
                dest_reg  <= '0;
                src_reg   <= '0;
                type_reg  <= '0;
            end else begin
                count_reg <= count_next;
                dest_reg  <= dest_next;
                src_reg   <= src_next;
                type_reg  <= type_next;
            end
        end
    end

endmodule

// ===== rtl/erff_queue.sv =====
// ----------------------------------------------------------------------------
// erff_queue
// Short first-in first-out queue of frame records between front and back.
// ----------------------------------------------------------------------------
module erff_queue import erff_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output frame_rec_t head_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    frame_rec_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign head_rec  = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/erff_back.sv =====
// ----------------------------------------------------------------------------
// erff_back
// Frame classification: judges the queued frame record against the config
// and holds the verdict in an output register until it is taken.
// ----------------------------------------------------------------------------
module erff_back import erff_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  filt_cfg_t            cfg,
    input  logic                 q_not_empty,
    input  frame_rec_t           q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_verdict,
    output logic [MAC_W-1:0]     m_sender_mac,
    output logic [PAYLOAD_W-1:0] m_payload_bytes
);

    logic                 valid_reg, valid_next;
    verdict_t             verdict_reg, verdict_next;
    logic [MAC_W-1:0]     sender_reg, sender_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [COUNT_W-1:0]   len_limit;
    logic [COUNT_W-1:0]   payload_len;
    logic                 len_bad, src_bad, dest_ok, short_frame;

    assign q_pop = q_not_empty && (!valid_reg || m_ready);

    // frame checks
    assign len_limit   = HDR_BYTES + COUNT_W'(cfg.max_payload);
    assign short_frame = q_head.frame_len < HDR_BYTES;
    assign len_bad     = short_frame || (q_head.frame_len > len_limit);
    assign src_bad     = (q_head.src_mac == '0) || q_head.src_mac[MCAST_BIT];
    assign dest_ok     = (q_head.dest_mac == cfg.station_mac)
                      || (q_head.dest_mac == MAC_BCAST)
                      || q_head.dest_mac[MCAST_BIT];
    assign payload_len = q_head.frame_len - HDR_BYTES;

    // verdict in priority order
    always_comb begin
        priority if (len_bad || src_bad) begin
            verdict_next = VERDICT_INVALID;
        end else if (!dest_ok) begin
            verdict_next = VERDICT_NOTUS;
        end else if (q_head.ether_type == TYPE_ARP) begin
            verdict_next = VERDICT_ARP;
        end else if (q_head.ether_type == TYPE_IPV4) begin
            verdict_next = VERDICT_IPV4;
        end else begin
            verdict_next = VERDICT_UNSUP;
        end
    end

    // result fields
    always_comb begin
        sender_next  = short_frame ? '0 : q_head.src_mac;
        payload_next = '0;
        if (verdict_next == VERDICT_ARP || verdict_next == VERDICT_IPV4) begin
            payload_next = payload_len[PAYLOAD_W-1:0];
        end
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            verdict_reg <= verdict_next;
            sender_reg  <= sender_next;
            payload_reg <= payload_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_verdict       = verdict_reg;
    assign m_sender_mac    = sender_reg;
    assign m_payload_bytes = payload_reg;

endmodule

// ===== rtl/ethernet_rx_frame_filter.sv =====
// Throughput: one frame byte accepted per clock, back to back across frames,
// while the record queue is not full. The last byte's record is queued, and
// the classifier registers its verdict once the output register is free.
// The two-entry record queue lets intake run while a verdict waits.
// Reset (aresetn, synchronous): clears byte count, header capture, queue and
// output valid; station_mac returns to zero and max_payload to 1500.
// ----------------------------------------------------------------------------
// ethernet_rx_frame_filter
// Receive address filter: captures the Ethernet header of each frame and
// returns one verdict, the sender address and the payload length per frame.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_filter import erff_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // byte stream in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_last_byte,
    // verdicts out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_verdict,
    output logic [MAC_W-1:0]      m_sender_mac,
    output logic [PAYLOAD_W-1:0]  m_payload_bytes
);

    logic [MAC_W-1:0]     station_mac_reg;
    logic [PAYLOAD_W-1:0] max_payload_reg;
    filt_cfg_t            cfg;
    logic                 q_full, q_push, q_pop, q_not_empty;
    frame_rec_t           q_push_rec, q_head;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_mac_reg <= '0;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STATION_MAC: station_mac_reg <= cfg_data[MAC_W-1:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[PAYLOAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.station_mac = station_mac_reg;
    assign cfg.max_payload = max_payload_reg;

    erff_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_rec  (q_push_rec)
    );

    erff_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_rec  (q_push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_rec  (q_head)
    );

    erff_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_sender_mac    (m_sender_mac),
        .m_payload_bytes (m_payload_bytes)
    );

endmodule
